// ----- src/snu_pkg.sv -----
`default_nettype none
package snu_pkg;

   localparam int WORD_BITS   = 32;
   localparam int FRAC_BITS   = 16;
   localparam int SLOTS       = 13;
   localparam int FRONT_DEPTH = 4;
   localparam int PIPE_DEPTH  = 10;
   localparam int RSP_DEPTH   = 16;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic [3:0] slot_type;
   typedef logic [7:0] nrn_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

   localparam logic CSR_TIME_STEP = 1'b0;
   localparam logic CSR_ADAPTIVE  = 1'b1;

   localparam slot_type SLOT_K      = 4'd0;
   localparam slot_type SLOT_A      = 4'd1;
   localparam slot_type SLOT_B      = 4'd2;
   localparam slot_type SLOT_D      = 4'd3;
   localparam slot_type SLOT_INV_C  = 4'd4;
   localparam slot_type SLOT_VR     = 4'd5;
   localparam slot_type SLOT_VT     = 4'd6;
   localparam slot_type SLOT_VPEAK  = 4'd7;
   localparam slot_type SLOT_C      = 4'd8;
   localparam slot_type SLOT_DELTA  = 4'd9;
   localparam slot_type SLOT_BIAS   = 4'd10;
   localparam slot_type SLOT_MULT   = 4'd11;
   localparam slot_type SLOT_DECAY  = 4'd12;

   typedef struct packed {
      logic     clamp;
      word_type val;
   } sword_type;

   // Classified request as it leaves the front queue.
   typedef struct packed {
      logic     is_load;
      slot_type slot;
      logic     slot_ok;
      logic     is_vr;
      logic     in_range;
      nrn_type  neuron;
      word_type opnd;
   } req_type;

   typedef struct packed {
      nrn_type  neuron;
      logic     spike;
      word_type potential;
      logic     saturated;
   } rsp_type;

   function automatic sword_type sadd(input word_type x, input word_type y);
      logic signed [WORD_BITS:0] s;
      sword_type r;
      s = {x[WORD_BITS-1], x} + {y[WORD_BITS-1], y};
      r.clamp = s[WORD_BITS] != s[WORD_BITS-1];
      r.val = r.clamp ? (s[WORD_BITS] ? WORD_MIN : WORD_MAX) : s[WORD_BITS-1:0];
      return r;
   endfunction

   function automatic sword_type ssub(input word_type x, input word_type y);
      logic signed [WORD_BITS:0] s;
      sword_type r;
      s = {x[WORD_BITS-1], x} - {y[WORD_BITS-1], y};
      r.clamp = s[WORD_BITS] != s[WORD_BITS-1];
      r.val = r.clamp ? (s[WORD_BITS] ? WORD_MIN : WORD_MAX) : s[WORD_BITS-1:0];
      return r;
   endfunction

   // Exact product, floor shift by the fraction width, then clamp to the word.
   function automatic sword_type qmul(input word_type x, input word_type y);
      logic signed [2*WORD_BITS-1:0] p;
      logic [2*WORD_BITS-FRAC_BITS-1:0] q;
      logic [2*WORD_BITS-FRAC_BITS-WORD_BITS:0] top;
      sword_type r;
      p = x * y;
      q = p[2*WORD_BITS-1:FRAC_BITS];
      top = q[2*WORD_BITS-FRAC_BITS-1:WORD_BITS-1];
      r.clamp = (top != '0) && (top != '1);
      r.val = r.clamp ? (q[2*WORD_BITS-FRAC_BITS-1] ? WORD_MIN : WORD_MAX)
                      : q[WORD_BITS-1:0];
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- src/snu_front.sv -----
`default_nettype none
module snu_front #(
   parameter int NEURONS = 256
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                hold,
   input  wire logic                push,
   output logic                     full,
   input  wire logic                op,
   input  wire snu_pkg::nrn_type    neuron,
   input  wire snu_pkg::slot_type   param_index,
   input  wire snu_pkg::word_type   param_value,
   input  wire snu_pkg::word_type   current,
   output logic                     head_valid,
   output snu_pkg::req_type         head,
   input  wire logic                pop
);
   import snu_pkg::*;

   localparam int PW = $clog2(FRONT_DEPTH);

   req_type           queue_ff [FRONT_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW:0]       count_ff, count_in;
   req_type           item;
   logic              accept;

   always_comb begin
      item.is_load  = op == OP_LOAD;
      item.slot     = param_index;
      item.slot_ok  = param_index <= SLOT_DECAY;
      item.is_vr    = param_index == SLOT_VR;
      item.in_range = 32'(neuron) < 32'(NEURONS);
      item.neuron   = neuron;
      item.opnd     = (op == OP_LOAD) ? param_value : current;
   end

   assign full       = hold || (count_ff == (PW+1)'(FRONT_DEPTH));
   assign accept     = push && !full;
   assign head_valid = count_ff != '0;
   assign head       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(accept) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

endmodule
`default_nettype wire

// ----- src/snu_rsp_fifo.sv -----
`default_nettype none
module snu_rsp_fifo (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire snu_pkg::rsp_type    push_data,
   input  wire logic                pop,
   output logic                     empty,
   output snu_pkg::rsp_type         head,
   output logic [$clog2(snu_pkg::RSP_DEPTH):0] count
);
   import snu_pkg::*;

   localparam int PW = $clog2(RSP_DEPTH);

   rsp_type         queue_ff [RSP_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]     count_ff;
   logic            take;

   assign empty = count_ff == '0;
   assign head  = queue_ff[rd_ptr_ff];
   assign count = count_ff;
   assign take  = pop && !empty;

   // The back end issues only against free space, so push never meets a full queue.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
         rd_ptr_ff <= take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
         count_ff  <= count_ff + (PW+1)'(push) - (PW+1)'(take);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ----- src/snu_back.sv -----
`default_nettype none
module snu_back #(
   parameter int NEURONS = 256
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [30:0]         time_step,
   input  wire logic                adaptive_mode,
   input  wire logic                head_valid,
   input  wire snu_pkg::req_type    head,
   output logic                     pop,
   output logic                     clearing,
   input  wire logic [$clog2(snu_pkg::RSP_DEPTH):0] rsp_count,
   output logic                     rsp_push,
   output snu_pkg::rsp_type         rsp_data
);
   import snu_pkg::*;

   localparam int IW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
   localparam int CW = $clog2(RSP_DEPTH);

   typedef logic [IW-1:0] idx_type;

   typedef struct packed {
      logic     is_load;
      slot_type slot;
      logic     slot_ok;
      logic     is_vr;
      logic     in_range;
      nrn_type  neuron;
      word_type opnd;
      word_type v, u, t;
      word_type k, a, b, inv_c, bias, vpeak, c, d, mult, decay;
      word_type d1, d2, m1, m2, s, e, du, dv, pv, pu, vn, un, eff, tdec, tm;
      logic     tm_clamp;
      logic     spike;
      logic     sat;
   } pipe_type;

   word_type  v_mem [NEURONS];
   word_type  u_mem [NEURONS];
   word_type  t_mem [NEURONS];
   word_type  rd_v_ff, rd_u_ff, rd_t_ff;
   word_type  rd_par_ff [SLOTS];

   logic      clear_ff;
   idx_type   clr_idx_ff;

   logic [PIPE_DEPTH-1:0] valid_ff;
   nrn_type   nrn_ff [PIPE_DEPTH];
   logic      hazard;
   logic      issue;
   idx_type   iss_idx, wb_idx;
   logic [CW+1:0] occupancy;

   pipe_type  pipe1_in, pipe1_ff, pipe2_in, pipe2_ff, pipe3_in, pipe3_ff;
   pipe_type  pipe4_in, pipe4_ff, pipe5_in, pipe5_ff, pipe6_in, pipe6_ff;
   pipe_type  pipe7_in, pipe7_ff, pipe8_in, pipe8_ff, pipe9_in, pipe9_ff;
   pipe_type  pipe10_in, pipe10_ff;

   word_type  dt_word;
   logic      wb_valid, wb_upd, st_we, par_we;
   word_type  wb_v, wb_u, wb_t;
   logic      wb_sat;

   assign dt_word  = {1'b0, time_step};
   assign clearing = clear_ff;
   assign iss_idx  = idx_type'(head.neuron);

   // An item waits while any earlier item for the same neuron is still in flight.
   always_comb begin
      hazard = 1'b0;
      for (int i = 0; i < PIPE_DEPTH; i++) begin
         if (valid_ff[i] && nrn_ff[i] == head.neuron) begin
            hazard = 1'b1;
         end
      end
   end

   assign occupancy = (CW+2)'($countones(valid_ff)) + (CW+2)'(rsp_count);
   assign issue     = head_valid && !clear_ff && !hazard
                      && (occupancy < (CW+2)'(RSP_DEPTH));
   assign pop       = issue;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff   <= 1'b1;
         clr_idx_ff <= '0;
         valid_ff   <= '0;
      end else begin
         if (clear_ff) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
            if (clr_idx_ff == idx_type'(NEURONS - 1)) begin
               clear_ff <= 1'b0;
            end
         end
         valid_ff <= {valid_ff[PIPE_DEPTH-2:0], issue};
      end
   end

   always_ff @(posedge clock) begin
      nrn_ff[0] <= head.neuron;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
         nrn_ff[i] <= nrn_ff[i-1];
      end
      pipe1_ff  <= pipe1_in;
      pipe2_ff  <= pipe2_in;
      pipe3_ff  <= pipe3_in;
      pipe4_ff  <= pipe4_in;
      pipe5_ff  <= pipe5_in;
      pipe6_ff  <= pipe6_in;
      pipe7_ff  <= pipe7_in;
      pipe8_ff  <= pipe8_in;
      pipe9_ff  <= pipe9_in;
      pipe10_ff <= pipe10_in;
   end

   // State stores, cleared by a sweep after reset.
   always_ff @(posedge clock) begin
      if (clear_ff) begin
         v_mem[clr_idx_ff] <= '0;
         u_mem[clr_idx_ff] <= '0;
         t_mem[clr_idx_ff] <= '0;
      end else if (st_we) begin
         v_mem[wb_idx] <= wb_v;
         u_mem[wb_idx] <= wb_u;
         t_mem[wb_idx] <= wb_t;
      end
      rd_v_ff <= v_mem[iss_idx];
      rd_u_ff <= u_mem[iss_idx];
      rd_t_ff <= t_mem[iss_idx];
   end

   for (genvar g = 0; g < SLOTS; g++) begin : g_par
      word_type par_mem [NEURONS];
      always_ff @(posedge clock) begin
         if (par_we && pipe10_ff.slot == slot_type'(g)) begin
            par_mem[wb_idx] <= pipe10_ff.opnd;
         end
         rd_par_ff[g] <= par_mem[iss_idx];
      end
   end

   always_comb begin
      pipe1_in          = '0;
      pipe1_in.is_load  = head.is_load;
      pipe1_in.slot     = head.slot;
      pipe1_in.slot_ok  = head.slot_ok;
      pipe1_in.is_vr    = head.is_vr;
      pipe1_in.in_range = head.in_range;
      pipe1_in.neuron   = head.neuron;
      pipe1_in.opnd     = head.opnd;
   end

   // Stage 1: pick up the stored state and parameters, form the offsets.
   always_comb begin
      sword_type d1, d2;
      d1 = ssub(rd_v_ff, rd_par_ff[SLOT_VR]);
      d2 = ssub(rd_v_ff, rd_par_ff[SLOT_VT]);
      pipe2_in       = pipe1_ff;
      pipe2_in.v     = rd_v_ff;
      pipe2_in.u     = rd_u_ff;
      pipe2_in.t     = rd_t_ff;
      pipe2_in.k     = rd_par_ff[SLOT_K];
      pipe2_in.a     = rd_par_ff[SLOT_A];
      pipe2_in.b     = rd_par_ff[SLOT_B];
      pipe2_in.inv_c = rd_par_ff[SLOT_INV_C];
      pipe2_in.bias  = rd_par_ff[SLOT_BIAS];
      pipe2_in.vpeak = rd_par_ff[SLOT_VPEAK];
      pipe2_in.c     = rd_par_ff[SLOT_C];
      pipe2_in.d     = rd_par_ff[SLOT_D];
      pipe2_in.mult  = rd_par_ff[SLOT_MULT];
      pipe2_in.decay = rd_par_ff[SLOT_DECAY];
      pipe2_in.d1    = d1.val;
      pipe2_in.d2    = d2.val;
      pipe2_in.sat   = d1.clamp | d2.clamp;
   end

   always_comb begin
      sword_type m1, m2;
      m1 = qmul(pipe2_ff.k, pipe2_ff.d1);
      m2 = qmul(pipe2_ff.b, pipe2_ff.d1);
      pipe3_in     = pipe2_ff;
      pipe3_in.m1  = m1.val;
      pipe3_in.m2  = m2.val;
      pipe3_in.sat = pipe2_ff.sat | m1.clamp | m2.clamp;
   end

   always_comb begin
      sword_type s, e;
      s = qmul(pipe3_ff.m1, pipe3_ff.d2);
      e = ssub(pipe3_ff.m2, pipe3_ff.u);
      pipe4_in     = pipe3_ff;
      pipe4_in.s   = s.val;
      pipe4_in.e   = e.val;
      pipe4_in.sat = pipe3_ff.sat | s.clamp | e.clamp;
   end

   always_comb begin
      sword_type s, du;
      s  = ssub(pipe4_ff.s, pipe4_ff.u);
      du = qmul(pipe4_ff.a, pipe4_ff.e);
      pipe5_in     = pipe4_ff;
      pipe5_in.s   = s.val;
      pipe5_in.du  = du.val;
      pipe5_in.sat = pipe4_ff.sat | s.clamp | du.clamp;
   end

   always_comb begin
      sword_type s1, s2;
      s1 = sadd(pipe5_ff.s, pipe5_ff.opnd);
      s2 = sadd(s1.val, pipe5_ff.bias);
      pipe6_in     = pipe5_ff;
      pipe6_in.s   = s2.val;
      pipe6_in.sat = pipe5_ff.sat | s1.clamp | s2.clamp;
   end

   always_comb begin
      sword_type dv;
      dv = qmul(pipe6_ff.s, pipe6_ff.inv_c);
      pipe7_in     = pipe6_ff;
      pipe7_in.dv  = dv.val;
      pipe7_in.sat = pipe6_ff.sat | dv.clamp;
   end

   always_comb begin
      sword_type pv, pu;
      pv = qmul(dt_word, pipe7_ff.dv);
      pu = qmul(dt_word, pipe7_ff.du);
      pipe8_in     = pipe7_ff;
      pipe8_in.pv  = pv.val;
      pipe8_in.pu  = pu.val;
      pipe8_in.sat = pipe7_ff.sat | pv.clamp | pu.clamp;
   end

   // Stage 8: integrate, and in adaptive mode form the raised threshold and its decay.
   always_comb begin
      sword_type vn, un, eff, tdec;
      vn   = sadd(pipe8_ff.v, pipe8_ff.pv);
      un   = sadd(pipe8_ff.u, pipe8_ff.pu);
      eff  = sadd(pipe8_ff.vpeak, pipe8_ff.t);
      tdec = qmul(pipe8_ff.t, pipe8_ff.decay);
      pipe9_in      = pipe8_ff;
      pipe9_in.vn   = vn.val;
      pipe9_in.un   = un.val;
      pipe9_in.eff  = eff.val;
      pipe9_in.tdec = tdec.val;
      pipe9_in.sat  = pipe8_ff.sat | vn.clamp | un.clamp
                      | (adaptive_mode & (eff.clamp | tdec.clamp));
   end

   always_comb begin
      sword_type tm;
      tm = qmul(pipe9_ff.eff, pipe9_ff.mult);
      pipe10_in          = pipe9_ff;
      pipe10_in.spike    = adaptive_mode ? (pipe9_ff.vn >= pipe9_ff.eff)
                                         : (pipe9_ff.vn >= pipe9_ff.vpeak);
      pipe10_in.tm       = tm.val;
      pipe10_in.tm_clamp = tm.clamp;
   end

   // Stage 10: reset on a spike, write back and hand over the result.
   always_comb begin
      sword_type ud, tr;
      logic      fire;
      ud   = sadd(pipe10_ff.un, pipe10_ff.d);
      tr   = ssub(pipe10_ff.tm, pipe10_ff.vpeak);
      wb_valid = valid_ff[PIPE_DEPTH-1];
      wb_idx   = idx_type'(pipe10_ff.neuron);
      wb_upd   = !pipe10_ff.is_load && pipe10_ff.in_range;
      fire     = pipe10_ff.spike;
      if (pipe10_ff.is_load) begin
         wb_v = pipe10_ff.opnd;
         wb_u = '0;
         wb_t = '0;
      end else begin
         wb_v = fire ? pipe10_ff.c : pipe10_ff.vn;
         wb_u = fire ? ud.val : pipe10_ff.un;
         if (!adaptive_mode) begin
            wb_t = pipe10_ff.t;
         end else begin
            wb_t = fire ? tr.val : pipe10_ff.tdec;
         end
      end
      wb_sat = pipe10_ff.sat
               | (fire & ud.clamp)
               | (fire & adaptive_mode & (pipe10_ff.tm_clamp | tr.clamp));
      par_we = wb_valid && pipe10_ff.in_range && pipe10_ff.is_load && pipe10_ff.slot_ok;
      st_we  = wb_valid && (wb_upd || (par_we && pipe10_ff.is_vr));

      rsp_push           = wb_valid;
      rsp_data.neuron    = pipe10_ff.neuron;
      rsp_data.spike     = wb_upd && fire;
      rsp_data.saturated = wb_upd && wb_sat;
      if (!pipe10_ff.in_range) begin
         rsp_data.potential = '0;
      end else if (pipe10_ff.is_load) begin
         rsp_data.potential = (pipe10_ff.slot_ok && pipe10_ff.is_vr) ? pipe10_ff.opnd
                                                                     : pipe10_ff.v;
      end else begin
         rsp_data.potential = wb_v;
      end
   end

endmodule
`default_nettype wire

// ----- src/spiking_neuron_update.sv -----
`default_nettype none
// Izhikevich neuron engine with one forward Euler step per update request, in signed
// Q16.16 with clamping; a load request writes one of 13 parameter words of a neuron, and
// loading the rest potential also resets that neuron's state. Every request gives exactly
// one response, in order. The block takes one request per clock while req_full is low: a
// front queue holds incoming requests, a ten-stage datapath (at most one 32x32 multiply
// level per stage) executes them, and a response queue of 16 entries holds results.
// A request to a neuron that is still in the datapath waits until the earlier one has
// written back, so the datapath holds at most one request per neuron at a time. After
// reset the state stores are cleared one neuron per cycle, and req_full stays high until
// the sweep is done. Write the configuration registers only while the block is idle.
module spiking_neuron_update #(
   parameter int NEURONS = 256
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_push,
   output logic                     req_full,
   input  wire logic                req_op,
   input  wire logic [7:0]          req_neuron,
   input  wire logic [3:0]          req_param_index,
   input  wire logic signed [31:0]  req_param_value,
   input  wire logic signed [31:0]  req_current,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop,
   output logic [7:0]               rsp_neuron_out,
   output logic                     rsp_spike,
   output logic signed [31:0]       rsp_potential,
   output logic                     rsp_saturated,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic                csr_index,
   input  wire logic [31:0]         csr_data
);
   import snu_pkg::*;

   logic [30:0]  time_step_ff;
   logic         adaptive_ff;
   logic         hold;
   logic         head_valid;
   req_type      head;
   logic         pop;
   logic [$clog2(RSP_DEPTH):0] rsp_count;
   logic         rsp_push;
   rsp_type      rsp_data, rsp_head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= 31'd65536;
         adaptive_ff  <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TIME_STEP: time_step_ff <= csr_data[30:0];
            CSR_ADAPTIVE:  adaptive_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   snu_front #(.NEURONS(NEURONS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .hold        (hold),
      .push        (req_push),
      .full        (req_full),
      .op          (req_op),
      .neuron      (req_neuron),
      .param_index (req_param_index),
      .param_value (req_param_value),
      .current     (req_current),
      .head_valid  (head_valid),
      .head        (head),
      .pop         (pop)
   );

   snu_back #(.NEURONS(NEURONS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .time_step     (time_step_ff),
      .adaptive_mode (adaptive_ff),
      .head_valid    (head_valid),
      .head          (head),
      .pop           (pop),
      .clearing      (hold),
      .rsp_count     (rsp_count),
      .rsp_push      (rsp_push),
      .rsp_data      (rsp_data)
   );

   snu_rsp_fifo u_rsp (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_data),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (rsp_head),
      .count     (rsp_count)
   );

   assign rsp_neuron_out = rsp_head.neuron;
   assign rsp_spike      = rsp_head.spike;
   assign rsp_potential  = rsp_head.potential;
   assign rsp_saturated  = rsp_head.saturated;

endmodule
`default_nettype wire
